// File: rtl/core/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Shared command codes and sequencer state type for the tagged message queue.
// ----------------------------------------------------------------------------
package tmq_pkg;

   // Request command codes (code 3 has no meaning and is served as a peek)
   localparam logic [1:0] CMD_PUSH = 2'd0;
   localparam logic [1:0] CMD_PEEK = 2'd1;
   localparam logic [1:0] CMD_POP  = 2'd2;

   // Sequencer states, one-hot
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// File: rtl/core/tagged_message_queue.sv
// ----------------------------------------------------------------------------
// tagged_message_queue
// Ordered queue of tagged messages with push, peek-oldest-matching and
// pop-oldest-matching, the pop closing up the entries behind it in order.
// ----------------------------------------------------------------------------
// Entries live in one RAM (tag and payload side by side) with a registered
// read port. Every request first scans the fill_level stored entries, one
// RAM read per cycle, to count matches and capture the oldest match; a pop
// then moves each later entry down one place, again one read and one write
// per cycle, both passes paced by the single RAM read port. A new request is
// taken once the previous one is written to the output register, while that
// result may still be waiting to be taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
module tagged_message_queue #(
   parameter int DEPTH        = 16,
   parameter int PAYLOAD_BITS = 32,
   parameter int TAG_BITS     = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_command,
   input  logic [TAG_BITS-1:0]        req_target_tag,
   input  logic [PAYLOAD_BITS-1:0]    req_push_payload,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic [TAG_BITS-1:0]        rsp_message_tag,
   output logic [PAYLOAD_BITS-1:0]    rsp_message_payload,
   output logic [$clog2(DEPTH+1)-1:0] rsp_match_count,
   output logic                       rsp_overflow
);

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int EW = TAG_BITS + PAYLOAD_BITS;
   localparam logic [TAG_BITS-1:0] TAG_NONE = '0;
   localparam logic [TAG_BITS-1:0] TAG_ALL  = '1;

   tmq_pkg::state_type st_ff, st_in;

   logic [1:0]              cmd_ff, cmd_in;
   logic [TAG_BITS-1:0]     tag_ff, tag_in;
   logic [PAYLOAD_BITS-1:0] pay_ff, pay_in;
   logic [CW-1:0]           fill_ff, fill_in;
   logic [CW-1:0]           idx_ff, idx_in;
   logic                    pend_ff, pend_in;
   logic [IW-1:0]           chk_ff, chk_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    hit_ff, hit_in;
   logic [IW-1:0]           pos_ff, pos_in;
   logic [EW-1:0]           hdat_ff, hdat_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [TAG_BITS-1:0]     rsp_tag_ff, rsp_tag_in;
   logic [PAYLOAD_BITS-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CW-1:0]           rsp_cnt_ff, rsp_cnt_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;

   logic                    ram_we;
   logic [IW-1:0]           ram_waddr;
   logic [EW-1:0]           ram_wdata;
   logic [IW-1:0]           ram_raddr;
   logic [EW-1:0]           ram_rdata;

   logic                    out_free;
   logic                    issue;
   logic                    match;
   logic                    is_push;
   logic                    is_pop;
   logic                    full;
   logic [TAG_BITS-1:0]     rd_tag;
   logic [CW-1:0]           next_pos;

   // Entry store: tag in the upper bits, payload below
   tmq_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_entries (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // Status decode
   assign req_stall = (st_ff != tmq_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issue     = ((st_ff == tmq_pkg::ST_SCAN) || (st_ff == tmq_pkg::ST_SHIFT))
                      && (idx_ff < fill_ff);
   assign rd_tag    = ram_rdata[EW-1 -: TAG_BITS];
   assign match     = pend_ff && (st_ff == tmq_pkg::ST_SCAN)
                      && ((tag_ff == TAG_ALL)
                          || ((tag_ff != TAG_NONE) && (rd_tag == tag_ff)));
   assign is_push   = (cmd_ff == tmq_pkg::CMD_PUSH);
   assign is_pop    = (cmd_ff == tmq_pkg::CMD_POP);
   assign full      = (fill_ff == CW'(DEPTH));
   assign next_pos  = CW'(pos_ff) + CW'(1);
   assign ram_raddr = idx_ff[IW-1:0];

   // Write back: close up on pop, append on push unless full
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = chk_ff - IW'(1);
      ram_wdata = ram_rdata;
      if ((st_ff == tmq_pkg::ST_SHIFT) && pend_ff) begin
         ram_we = 1'b1;
      end else if ((st_ff == tmq_pkg::ST_DONE) && out_free && is_push && !full) begin
         ram_we    = 1'b1;
         ram_waddr = fill_ff[IW-1:0];
         ram_wdata = {tag_ff, pay_ff};
      end
   end

   // Sequencer and scan datapath
   always_comb begin
      st_in   = st_ff;
      cmd_in  = cmd_ff;
      tag_in  = tag_ff;
      pay_in  = pay_ff;
      fill_in = fill_ff;
      idx_in  = issue ? (idx_ff + CW'(1)) : idx_ff;
      pend_in = issue;
      chk_in  = idx_ff[IW-1:0];
      cnt_in  = cnt_ff;
      hit_in  = hit_ff;
      pos_in  = pos_ff;
      hdat_in = hdat_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_found_in = rsp_found_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_pay_in   = rsp_pay_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      unique case (st_ff)
         tmq_pkg::ST_IDLE: begin
            // take a request and start the scan from the head
            if (req_valid) begin
               cmd_in = req_command;
               tag_in = req_target_tag;
               pay_in = req_push_payload;
               idx_in = '0;
               cnt_in = '0;
               hit_in = 1'b0;
               st_in  = tmq_pkg::ST_SCAN;
            end
         end
         tmq_pkg::ST_SCAN: begin
            // count matches and capture the oldest one
            if (match) begin
               cnt_in = cnt_ff + CW'(1);
               if (!hit_ff) begin
                  hit_in  = 1'b1;
                  pos_in  = chk_ff;
                  hdat_in = ram_rdata;
               end
            end
            if (!issue && !pend_ff) begin
               if (is_pop && hit_ff && (next_pos < fill_ff)) begin
                  idx_in = next_pos;
                  st_in  = tmq_pkg::ST_SHIFT;
               end else begin
                  st_in = tmq_pkg::ST_DONE;
               end
            end
         end
         tmq_pkg::ST_SHIFT: begin
            // move later entries down one place until the tail is reached
            if (!issue && !pend_ff) begin
               st_in = tmq_pkg::ST_DONE;
            end
         end
         tmq_pkg::ST_DONE: begin
            // load the result and commit the fill level
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               rsp_tag_in   = (!is_push && hit_ff) ? hdat_ff[EW-1 -: TAG_BITS] : '0;
               rsp_pay_in   = (!is_push && hit_ff) ? hdat_ff[PAYLOAD_BITS-1:0] : '0;
               rsp_cnt_in   = cnt_ff;
               rsp_ovf_in   = is_push && full;
               if (is_push && !full) begin
                  fill_in = fill_ff + CW'(1);
               end else if (is_pop && hit_ff) begin
                  fill_in = fill_ff - CW'(1);
               end
               st_in = tmq_pkg::ST_IDLE;
            end
         end
         default: begin
            st_in = tmq_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= tmq_pkg::ST_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tag_ff       <= tag_in;
      pay_ff       <= pay_in;
      idx_ff       <= idx_in;
      chk_ff       <= chk_in;
      cnt_ff       <= cnt_in;
      hit_ff       <= hit_in;
      pos_ff       <= pos_in;
      hdat_ff      <= hdat_in;
      rsp_found_ff <= rsp_found_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_pay_ff   <= rsp_pay_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_message_tag     = rsp_tag_ff;
   assign rsp_message_payload = rsp_pay_ff;
   assign rsp_match_count     = rsp_cnt_ff;
   assign rsp_overflow        = rsp_ovf_ff;

`ifndef ASSERT_OFF
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CW'(DEPTH))
      else $error("fill level beyond depth");

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((st_ff == tmq_pkg::ST_SHIFT) || (st_ff == tmq_pkg::ST_DONE)))
      else $error("entry write outside shift or commit");

   a_fill_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$stable(fill_ff)) |-> $past(st_ff == tmq_pkg::ST_DONE))
      else $error("fill level changed outside commit");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (st_ff == tmq_pkg::ST_SCAN))
      else $error("accepted item did not start a scan");

   a_ovf_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> ((rsp_message_tag == '0)
                                       && (rsp_message_payload == '0)))
      else $error("dropped push returned entry data");
`endif

endmodule

// File: rtl/core/tmq_ram.sv
// ----------------------------------------------------------------------------
// tmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module tmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
